// ===== hdl/lccd_pkg.sv =====
// shared constants and types for the lru chunk cache directory
`timescale 1ns / 1ps

package lccd_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ID_W        = 32;
    localparam int CAP_W       = 7;
    localparam int FILL_W      = 7;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef struct packed {
        logic capture;
        logic update;
    } lccd_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_UPD  = 2'b10
    } lccd_state_t;

endpackage

// ===== hdl/lccd_ctrl.sv =====
// request sequencer for the lru chunk cache directory
`timescale 1ns / 1ps

module lccd_ctrl
    import lccd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output lccd_cmd_t cmd
);

    lccd_state_t state_reg;
    lccd_state_t state_next;
    logic        done_reg;
    logic        done_next;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == ST_UPD);
    assign done = done_reg;

endmodule

// ===== hdl/lccd_datapath.sv =====
// recency cell chain, match logic and result registers
`timescale 1ns / 1ps

module lccd_datapath
    import lccd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lccd_cmd_t         cmd,
    input  logic [ID_W-1:0]   chunk_id,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    output logic              hit,
    output logic              evicted_valid,
    output logic [ID_W-1:0]   evicted_id,
    output logic [FILL_W-1:0] fill_count
);

    logic [ID_W-1:0]   cells_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CAP_W-1:0]  cap_reg;

    logic [ID_W-1:0]   id_reg;
    logic              hit_reg;
    logic              evict_reg;
    logic [ID_W-1:0]   tail_reg;
    logic [IDX_W-1:0]  upto_reg;
    logic [CNT_W-1:0]  newcnt_reg;

    logic              hit_out_reg;
    logic              ev_out_reg;
    logic [ID_W-1:0]   ev_id_out_reg;
    logic [FILL_W-1:0] fill_out_reg;

    logic              any_match;
    logic [IDX_W-1:0]  hit_idx;
    logic [ID_W-1:0]   tail_id;
    logic [CMP_W-1:0]  eff_cap;
    logic [CMP_W-1:0]  cap_ext;
    logic              evict;
    logic [IDX_W-1:0]  upto;

    // per-cell compare, one match at most since held ids are unique
    always_comb
    begin
        any_match = 1'b0;
        hit_idx   = '0;
        tail_id   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if ((CNT_W'(i) < count_reg) && (cells_reg[i] == chunk_id))
            begin
                any_match = 1'b1;
                hit_idx   = hit_idx | IDX_W'(i);
            end
            if (CNT_W'(i + 1) == count_reg)
            begin
                tail_id = tail_id | cells_reg[i];
            end
        end
    end

    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        eff_cap = cap_ext;
        priority if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(MAX_ENTRIES))
        begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
        evict = !any_match && (CMP_W'(count_reg) >= eff_cap) && (count_reg != '0);
        priority if (any_match)
        begin
            upto       = hit_idx;
            count_next = count_reg;
        end
        else if (evict)
        begin
            upto       = IDX_W'(count_reg - CNT_W'(1));
            count_next = count_reg;
        end
        else
        begin
            upto       = IDX_W'(count_reg);
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            id_reg     <= chunk_id;
            hit_reg    <= any_match;
            evict_reg  <= evict;
            tail_reg   <= tail_id;
            upto_reg   <= upto;
            newcnt_reg <= count_next;
        end
        if (cmd.update)
        begin
            hit_out_reg   <= hit_reg;
            ev_out_reg    <= evict_reg;
            ev_id_out_reg <= evict_reg ? tail_reg : '0;
            fill_out_reg  <= FILL_W'(newcnt_reg);
        end
    end

    // shift cells 1..upto down by one, new id into the front
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            cells_reg[0] <= id_reg;
            for (int g = 1; g < MAX_ENTRIES; g++)
            begin
                if (IDX_W'(g) <= upto_reg)
                begin
                    cells_reg[g] <= cells_reg[g-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            if (cmd.update)
            begin
                count_reg <= newcnt_reg;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    assign hit           = hit_out_reg;
    assign evicted_valid = ev_out_reg;
    assign evicted_id    = ev_id_out_reg;
    assign fill_count    = fill_out_reg;

endmodule

// ===== hdl/lru_chunk_cache_directory.sv =====
// top level of the lru chunk cache directory
`timescale 1ns / 1ps

// usage:
// a request beat is taken at a rising edge with start high and busy low;
// chunk_id is sampled at that edge. the ids held are compared against it
// in one parallel pass over the cell chain in the same cycle.
// busy is then high for one cycle while the cell chain shifts and the
// fill count updates; a new request can be taken once busy is low again.
// one result beat per request: done is high for exactly one cycle, set at
// the edge that ends the busy cycle; hit, evicted_valid, evicted_id and
// fill_count are valid from it until the next result. the receiver
// cannot stall; the result registers are apart from the chain, so the
// next request is taken in the same cycle that a result is shown.
// requests do not overlap: the compare step and the shift step of the
// cell chain for one request end before the next request is taken.
// cfg_we writes cache_capacity from cfg_wdata; write only while idle.
// reset empties the directory and sets cache_capacity to 64, no clearing
// pass is needed since cells beyond the fill count are never read.

module lru_chunk_cache_directory
    import lccd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ID_W-1:0]   chunk_id,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    output logic              done,
    output logic              hit,
    output logic              evicted_valid,
    output logic [ID_W-1:0]   evicted_id,
    output logic [FILL_W-1:0] fill_count
);

    lccd_cmd_t cmd;

    lccd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    lccd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .chunk_id      (chunk_id),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_id    (evicted_id),
        .fill_count    (fill_count)
    );

endmodule

// ===== hdl/lccd_checker.sv =====
// port level checks for the lru chunk cache directory
`timescale 1ns / 1ps

module lccd_checker
    import lccd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic              hit,
    input logic              evicted_valid,
    input logic [ID_W-1:0]   evicted_id,
    input logic [FILL_W-1:0] fill_count
);

    // an accepted beat occupies exactly one busy cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result beat missing two cycles after request");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (!evicted_valid && (evicted_id == '0)))
        else $error("eviction reported on a hit");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((fill_count != '0) && (fill_count <= FILL_W'(MAX_ENTRIES))))
        else $error("fill count out of range");

endmodule

bind lru_chunk_cache_directory lccd_checker u_lccd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_id    (evicted_id),
    .fill_count    (fill_count)
);
